### src/sspc_pkg.sv
// Shared types and constants for the servo status packet checker.
`timescale 1ns / 1ps

package sspc_pkg;

  localparam int MAX_PARAMS = 64;
  localparam int COUNT_W    = 7;
  localparam int IDX_W      = $clog2(MAX_PARAMS + 12);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_PROTOCOL_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_ID   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PARAM_COUNT   = 2'd2;

  localparam logic [7:0]  SYNC_BYTE    = 8'hFF;
  localparam logic [7:0]  CRC_MARK     = 8'hFD;
  localparam logic [7:0]  STATUS_INSTR = 8'h55;
  localparam logic [15:0] CRC_POLY     = 16'h8005;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } sspc_in_t;

  typedef struct packed {
    logic       param_valid;
    logic [7:0] param_byte;
    logic       packet_done;
    logic [7:0] servo_error;
    logic       response_fault;
  } sspc_out_t;

endpackage

### src/servo_status_packet_checker_unit.sv
// Top level of the servo status packet checker: byte-wise header, sum and CRC-16 check.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid/in_ready/in_data) carries one received byte per beat,
//   with frame_start marking byte 0 of a new reception. Output channel
//   (out_valid/out_ready/out_data) returns exactly one result beat per input beat:
//   pass-through parameter byte, and on the last byte of the packet the servo
//   error byte and the invalid-response flag.
//   Configuration: cfg_we/cfg_index/cfg_data write mode, expected id and
//   parameter count; write only while no beat is in flight.
// Timing
//   The result beat is registered. Throughput is one byte per cycle while out_ready
//   drains the result register: header compares, the 8-bit sum and an unrolled
//   8-step CRC-16 of one byte sit between the packet state and the result register.
// Reset
//   rst clears the packet state, loads the register defaults (sum mode, id 1,
//   no parameters) and empties the result register.
// Stall
//   While out_ready is low a held result blocks further input; in_ready stays high
//   whenever the result register is empty or is being drained in the same cycle.
module servo_status_packet_checker_unit
  import sspc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sspc_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sspc_out_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [IDX_W-1:0] IDX_SYNC0   = IDX_W'(0);
  localparam logic [IDX_W-1:0] IDX_SYNC1   = IDX_W'(1);
  localparam logic [IDX_W-1:0] IDX_TWO     = IDX_W'(2);
  localparam logic [IDX_W-1:0] IDX_THREE   = IDX_W'(3);
  localparam logic [IDX_W-1:0] IDX_FOUR    = IDX_W'(4);
  localparam logic [IDX_W-1:0] IDX_FIVE    = IDX_W'(5);
  localparam logic [IDX_W-1:0] IDX_SIX     = IDX_W'(6);
  localparam logic [IDX_W-1:0] IDX_SEVEN   = IDX_W'(7);
  localparam logic [IDX_W-1:0] IDX_EIGHT   = IDX_W'(8);
  localparam logic [IDX_W-1:0] IDX_NINE    = IDX_W'(9);
  localparam logic [IDX_W-1:0] IDX_TEN     = IDX_W'(10);

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  logic               protocol_mode;
  logic [7:0]         expected_id;
  logic [COUNT_W-1:0] expected_param_count;

  logic [IDX_W-1:0]   byte_index;
  logic               header_good;
  logic [7:0]         sum_accum;
  logic [15:0]        crc_accum_reg;
  logic [7:0]         error_byte_reg;
  logic [7:0]         crc_low_received;

  logic [IDX_W-1:0]   byte_index_next;
  logic               header_good_next;
  logic [7:0]         sum_accum_next;
  logic [15:0]        crc_accum_reg_next;
  logic [7:0]         error_byte_reg_next;
  logic [7:0]         crc_low_received_next;

  logic               in_fire;
  logic [IDX_W-1:0]   n;
  logic [IDX_W-1:0]   last_idx;
  logic [IDX_W-1:0]   idx;
  logic [15:0]        crc_plen;
  logic [7:0]         b;
  logic               done_c;
  sspc_out_t          res_c;

  assign in_fire  = in_valid && in_ready;
  assign in_ready = !out_valid || out_ready;
  assign b        = in_data.rx_byte;

  assign n = (expected_param_count > COUNT_W'(MAX_PARAMS)) ? IDX_W'(MAX_PARAMS)
                                                            : IDX_W'(expected_param_count);
  assign last_idx = protocol_mode ? (n + IDX_TEN) : (n + IDX_FIVE);
  assign crc_plen = 16'(n) + 16'd4;

  always_comb begin
    logic       hg;
    logic [7:0] sum_b;
    logic [15:0] crc_b;
    logic [7:0] err_b;
    logic [7:0] low_b;
    logic       pv;
    logic       bad;

    if (in_data.frame_start) begin
      idx   = '0;
      hg    = 1'b1;
      sum_b = '0;
      crc_b = '0;
      err_b = '0;
      low_b = '0;
    end else begin
      idx   = byte_index;
      hg    = header_good;
      sum_b = sum_accum;
      crc_b = crc_accum_reg;
      err_b = error_byte_reg;
      low_b = crc_low_received;
    end

    if (protocol_mode) begin
      case (idx)
        IDX_SYNC0, IDX_SYNC1: if (b != SYNC_BYTE) hg = 1'b0;
        IDX_TWO:   if (b != CRC_MARK) hg = 1'b0;
        IDX_FOUR:  if (b != expected_id) hg = 1'b0;
        IDX_FIVE:  if (b != crc_plen[7:0]) hg = 1'b0;
        IDX_SIX:   if (b != crc_plen[15:8]) hg = 1'b0;
        IDX_SEVEN: if (b != STATUS_INSTR) hg = 1'b0;
        IDX_EIGHT: err_b = b;
        default: ;
      endcase
      pv = (idx >= IDX_NINE) && (idx < IDX_NINE + n);
    end else begin
      case (idx)
        IDX_SYNC0, IDX_SYNC1: if (b != SYNC_BYTE) hg = 1'b0;
        IDX_TWO:   if (b != expected_id) hg = 1'b0;
        IDX_THREE: if (b != 8'(n + IDX_TWO)) hg = 1'b0;
        IDX_FOUR:  err_b = b;
        default: ;
      endcase
      pv = (idx >= IDX_FIVE) && (idx < IDX_FIVE + n);
    end
    pv = pv && hg;

    done_c = (idx >= last_idx);
    bad    = 1'b0;

    byte_index_next       = idx;
    header_good_next      = hg;
    sum_accum_next        = sum_b;
    crc_accum_reg_next    = crc_b;
    error_byte_reg_next   = err_b;
    crc_low_received_next = low_b;

    res_c.param_valid    = pv;
    res_c.param_byte     = pv ? b : 8'h00;
    res_c.packet_done    = done_c;
    res_c.servo_error    = 8'h00;
    res_c.response_fault = 1'b0;

    if (done_c) begin
      if (protocol_mode) begin
        bad = ({b, low_b} != crc_b);
      end else begin
        bad = (b != ~sum_b);
      end
      if (!hg) begin
        bad = 1'b1;
      end else begin
        res_c.servo_error = err_b;
      end
      res_c.response_fault  = bad;
      byte_index_next       = '0;
      header_good_next      = 1'b1;
      sum_accum_next        = '0;
      crc_accum_reg_next    = '0;
      error_byte_reg_next   = '0;
      crc_low_received_next = '0;
    end else begin
      if (protocol_mode) begin
        if (idx + IDX_W'(1) < last_idx) begin
          crc_accum_reg_next = crc_byte(crc_b, b);
        end else begin
          crc_low_received_next = b;
        end
      end else if (idx >= IDX_TWO) begin
        sum_accum_next = sum_b + b;
      end
      byte_index_next = idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      protocol_mode        <= 1'b0;
      expected_id          <= 8'd1;
      expected_param_count <= '0;
      byte_index           <= '0;
      header_good          <= 1'b1;
      sum_accum            <= '0;
      crc_accum_reg        <= '0;
      error_byte_reg       <= '0;
      crc_low_received     <= '0;
      out_valid            <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PROTOCOL_MODE: protocol_mode        <= cfg_data[0];
          CFG_EXPECTED_ID:   expected_id          <= cfg_data;
          CFG_PARAM_COUNT:   expected_param_count <= cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (in_fire) begin
        byte_index       <= byte_index_next;
        header_good      <= header_good_next;
        sum_accum        <= sum_accum_next;
        crc_accum_reg    <= crc_accum_reg_next;
        error_byte_reg   <= error_byte_reg_next;
        crc_low_received <= crc_low_received_next;
        out_valid        <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data <= res_c;
    end
  end

  a_param_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.param_valid |-> out_data.param_byte == 8'h00)
    else $error("param_byte set without param_valid");

  a_report_only_on_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.packet_done |->
      out_data.servo_error == 8'h00 && !out_data.response_fault)
    else $error("error report outside the last byte");

  a_param_not_done: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.param_valid && out_data.packet_done))
    else $error("parameter beat flagged as last byte");

  a_clear_after_done: assert property (@(posedge clk) disable iff (rst)
    in_fire && done_c |=> byte_index == '0 && header_good && sum_accum == 8'h00)
    else $error("packet state not cleared after last byte");

endmodule

### verif/servo_status_packet_checker_unit_tb.sv
// Self-checking testbench for the servo status packet checker unit.
`timescale 1ns / 1ps

module servo_status_packet_checker_unit_tb;
  import sspc_pkg::*;

  localparam logic MODE_SUM = 1'b0;
  localparam logic MODE_CRC = 1'b1;

  typedef struct {
    sspc_in_t  beat;
    bit        typed;
    sspc_out_t want;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  sspc_in_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  sspc_out_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // register copies and packet state of the predictor
  logic        cur_mode;
  logic [7:0]  cur_id;
  logic [6:0]  cur_count;
  logic [7:0]  pk_index;
  logic        pk_header_ok;
  logic [7:0]  pk_sum;
  logic [15:0] pk_crc;
  logic [7:0]  pk_err;
  logic [7:0]  pk_crc_lo;

  sspc_out_t   expected_results[$];
  stim_row_t   directed_rows[$];
  logic [7:0]  packet_bytes[$];
  bit          idling = 1'b1;
  int          stall_left = 0;
  int          mismatches = 0;
  int          beats_sent = 0;
  int          results_seen = 0;
  int          packets_closed = 0;
  int          packets_flagged = 0;
  int          params_seen = 0;
  int          reg_writes = 0;
  sspc_out_t   want_now;

  servo_status_packet_checker_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [15:0] crc16_step(logic [15:0] c, logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      r = r[15] ? ((r << 1) ^ 16'h8005) : (r << 1);
    end
    return r;
  endfunction

  function automatic void clear_packet();
    pk_index     = '0;
    pk_header_ok = 1'b1;
    pk_sum       = '0;
    pk_crc       = '0;
    pk_err       = '0;
    pk_crc_lo    = '0;
  endfunction

  function automatic sspc_out_t predict_status_result(sspc_in_t x);
    sspc_out_t   r;
    int          n;
    int          last;
    int          idx;
    logic [15:0] plen;
    logic        bad;
    r = '0;
    if (x.frame_start) clear_packet();
    n    = (cur_count > MAX_PARAMS) ? MAX_PARAMS : cur_count;
    last = (cur_mode == MODE_CRC) ? n + 10 : n + 5;
    idx  = pk_index;
    if (cur_mode == MODE_CRC) begin
      plen = 16'(n + 4);
      case (idx)
        0, 1: if (x.rx_byte != SYNC_BYTE) pk_header_ok = 1'b0;
        2: if (x.rx_byte != CRC_MARK) pk_header_ok = 1'b0;
        4: if (x.rx_byte != cur_id) pk_header_ok = 1'b0;
        5: if (x.rx_byte != plen[7:0]) pk_header_ok = 1'b0;
        6: if (x.rx_byte != plen[15:8]) pk_header_ok = 1'b0;
        7: if (x.rx_byte != STATUS_INSTR) pk_header_ok = 1'b0;
        8: pk_err = x.rx_byte;
        default: ;
      endcase
      r.param_valid = (idx >= 9) && (idx < 9 + n);
    end else begin
      case (idx)
        0, 1: if (x.rx_byte != SYNC_BYTE) pk_header_ok = 1'b0;
        2: if (x.rx_byte != cur_id) pk_header_ok = 1'b0;
        3: if (x.rx_byte != 8'(n + 2)) pk_header_ok = 1'b0;
        4: pk_err = x.rx_byte;
        default: ;
      endcase
      r.param_valid = (idx >= 5) && (idx < 5 + n);
    end
    r.param_valid = r.param_valid && pk_header_ok;
    r.param_byte  = r.param_valid ? x.rx_byte : 8'h00;
    if (idx >= last) begin
      r.packet_done = 1'b1;
      if (cur_mode == MODE_CRC) bad = ({x.rx_byte, pk_crc_lo} != pk_crc);
      else bad = (x.rx_byte != ~pk_sum);
      if (!pk_header_ok) begin
        r.response_fault = 1'b1;
        r.servo_error    = 8'h00;
      end else begin
        r.response_fault = bad;
        r.servo_error    = pk_err;
      end
      clear_packet();
    end else begin
      if (cur_mode == MODE_CRC) begin
        if (idx + 1 < last) pk_crc = crc16_step(pk_crc, x.rx_byte);
        else pk_crc_lo = x.rx_byte;
      end else if (idx >= 2) begin
        pk_sum = pk_sum + x.rx_byte;
      end
      pk_index = 8'(idx + 1);
    end
    return r;
  endfunction

  task automatic log_mismatch(string field, int got, int want);
    mismatches++;
    if (mismatches <= 40)
      $display("mismatch on result %0d: %s got 0x%0h, want 0x%0h",
               results_seen, field, got, want);
  endtask

  task automatic send_beat(sspc_in_t x, bit typed, sspc_out_t want);
    sspc_out_t p;
    if (idling && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= x;
    do @(posedge clk); while (!in_ready);
    p = predict_status_result(x);
    expected_results.push_back(typed ? want : p);
    beats_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_PROTOCOL_MODE: cur_mode  = data[0];
      CFG_EXPECTED_ID:   cur_id    = data;
      CFG_PARAM_COUNT:   cur_count = data[6:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  function automatic void add_row(logic [7:0] b, logic st, bit typed,
                                  logic done, logic [7:0] serr, logic bad);
    stim_row_t row;
    row.beat.rx_byte          = b;
    row.beat.frame_start      = st;
    row.typed                 = typed;
    row.want                  = '0;
    row.want.packet_done      = done;
    row.want.servo_error      = serr;
    row.want.response_fault   = bad;
    directed_rows.push_back(row);
  endfunction

  // one packet for the current registers, mostly well formed
  task automatic send_packet();
    int          n;
    int          flaw;
    int          restart_at;
    int          keep;
    logic [7:0]  s;
    logic [15:0] c;
    sspc_in_t    x;
    n = (cur_count > MAX_PARAMS) ? MAX_PARAMS : cur_count;
    packet_bytes = {};
    packet_bytes.push_back(SYNC_BYTE);
    packet_bytes.push_back(SYNC_BYTE);
    if (cur_mode == MODE_CRC) begin
      packet_bytes.push_back(CRC_MARK);
      packet_bytes.push_back(8'($urandom_range(0, 255)));
      packet_bytes.push_back(cur_id);
      packet_bytes.push_back(8'(n + 4));
      packet_bytes.push_back(8'((n + 4) >> 8));
      packet_bytes.push_back(STATUS_INSTR);
    end else begin
      packet_bytes.push_back(cur_id);
      packet_bytes.push_back(8'(n + 2));
    end
    packet_bytes.push_back(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255)));
    repeat (n) packet_bytes.push_back(8'($urandom_range(0, 255)));
    if (cur_mode == MODE_CRC) begin
      c = '0;
      foreach (packet_bytes[k]) c = crc16_step(c, packet_bytes[k]);
      packet_bytes.push_back(c[7:0]);
      packet_bytes.push_back(c[15:8]);
    end else begin
      s = '0;
      for (int k = 2; k < packet_bytes.size(); k++) s = s + packet_bytes[k];
      packet_bytes.push_back(~s);
    end
    flaw       = $urandom_range(0, 9);
    restart_at = -1;
    case (flaw)
      0: begin
        keep = $urandom_range(0, packet_bytes.size() - 1);
        packet_bytes[keep] = packet_bytes[keep] ^ (8'h01 << $urandom_range(0, 7));
      end
      1: begin
        keep = $urandom_range(1, packet_bytes.size() - 1);
        packet_bytes = packet_bytes[0:keep-1];
      end
      2: repeat ($urandom_range(1, 4)) begin
        x.rx_byte     = 8'($urandom_range(0, 255));
        x.frame_start = 1'($urandom_range(0, 1));
        send_beat(x, 1'b0, '0);
      end
      3: restart_at = $urandom_range(1, packet_bytes.size() - 1);
      default: ;
    endcase
    foreach (packet_bytes[k]) begin
      x.rx_byte     = packet_bytes[k];
      x.frame_start = (k == 0) ? ($urandom_range(0, 3) != 0) : (k == restart_at);
      send_beat(x, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (out_data.packet_done) packets_closed++;
        if (out_data.packet_done && out_data.response_fault) packets_flagged++;
        if (out_data.param_valid) params_seen++;
        if (expected_results.size() == 0) begin
          log_mismatch("unexpected beat", 1, 0);
        end else begin
          want_now = expected_results.pop_front();
          if (out_data.param_valid !== want_now.param_valid)
            log_mismatch("param_valid", out_data.param_valid, want_now.param_valid);
          if (out_data.param_byte !== want_now.param_byte)
            log_mismatch("param_byte", out_data.param_byte, want_now.param_byte);
          if (out_data.packet_done !== want_now.packet_done)
            log_mismatch("packet_done", out_data.packet_done, want_now.packet_done);
          if (out_data.servo_error !== want_now.servo_error)
            log_mismatch("servo_error", out_data.servo_error, want_now.servo_error);
          if (out_data.response_fault !== want_now.response_fault)
            log_mismatch("response_fault", out_data.response_fault,
                         want_now.response_fault);
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (idling && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 11);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("servo_status_packet_checker_unit_tb failed");
    $finish;
  end

  initial begin
    int phase;
    int r;
    cur_mode  = MODE_SUM;
    cur_id    = 8'd1;
    cur_count = '0;
    clear_packet();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset registers: sum format, id 1, no parameters
    add_row(8'hFF, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0);
    add_row(8'hFF, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(8'h01, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(8'h02, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(8'h80, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(8'h7C, 1'b0, 1'b1, 1'b1, 8'h80, 1'b0);
    // bad first sync byte: error reported as zero
    add_row(8'h00, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(8'hFF, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(8'h01, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(8'h02, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(8'h55, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(8'h00, 1'b0, 1'b1, 1'b1, 8'h00, 1'b1);
    // next packet without a start mark, wrong checksum
    add_row(8'hFF, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(8'hFF, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(8'h01, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(8'h02, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(8'h00, 1'b0, 1'b1, 1'b1, 8'h00, 1'b1);
    // restart one byte into a packet, error byte at its top value
    add_row(8'hFF, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(8'hFF, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(8'hFF, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(8'h01, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(8'h02, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(8'hFF, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(8'hFD, 1'b0, 1'b1, 1'b1, 8'hFF, 1'b0);
    foreach (directed_rows[k])
      send_beat(directed_rows[k].beat, directed_rows[k].typed, directed_rows[k].want);

    phase = 0;
    while (beats_sent < 440) begin
      wait_drained();
      idling = (beats_sent > 380) ? 1'b0 : ($urandom_range(0, 3) != 0);
      case (phase)
        0: begin
          write_reg(CFG_PROTOCOL_MODE, CFG_DATA_W'(MODE_CRC));
          write_reg(CFG_EXPECTED_ID, 8'd253);
          write_reg(CFG_PARAM_COUNT, 8'd127);
        end
        1: begin
          write_reg(CFG_PROTOCOL_MODE, CFG_DATA_W'(MODE_SUM));
          write_reg(CFG_EXPECTED_ID, 8'd0);
          write_reg(CFG_PARAM_COUNT, 8'd64);
        end
        default: begin
          write_reg(CFG_PROTOCOL_MODE, CFG_DATA_W'($urandom_range(0, 1)));
          r = $urandom_range(0, 3);
          write_reg(CFG_EXPECTED_ID, (r == 0) ? 8'd0 : (r == 1) ? 8'd253 :
                                     8'($urandom_range(0, 253)));
          r = $urandom_range(0, 23);
          write_reg(CFG_PARAM_COUNT, (r == 0) ? 8'd64 : (r == 1) ? 8'($urandom_range(65, 127)) :
                                     (r == 2) ? 8'd0 : 8'($urandom_range(1, 8)));
        end
      endcase
      repeat ((phase < 2) ? 2 : $urandom_range(2, 6)) begin
        if (beats_sent < 440) begin
          send_packet();
          if ($urandom_range(0, 9) == 0) wait_drained();
        end
      end
      phase++;
    end

    wait_drained();
    repeat (8) @(posedge clk);
    $display("run covered %0d byte beats over %0d register settings (%0d writes)",
             beats_sent, phase, reg_writes);
    $display("%0d packets closed, %0d flagged invalid, %0d parameter bytes passed",
             packets_closed, packets_flagged, params_seen);
    if (mismatches == 0) begin
      $display("servo_status_packet_checker_unit_tb passed");
    end else begin
      $display("servo_status_packet_checker_unit_tb failed");
    end
    $finish;
  end

endmodule
